FILE: hdl/bpfl_pkg.sv
// Shared types, constants and codes for the block pool free list allocator.
`timescale 1ns / 1ps
package bpfl_pkg;

  localparam int DEF_MAX_BLOCKS   = 1024;
  localparam int DEF_HEADER_BYTES = 16;
  localparam int DEF_ADDR_WIDTH   = 32;

  localparam int NUMB_W      = 11;
  localparam int BYTES_W     = 17;
  localparam int POOL_W      = 8;
  localparam int BASE_W      = 32;
  localparam int IDXF_W      = 10;
  localparam int STATUS_W    = 2;
  localparam int ADDRF_W     = 32;
  localparam int COUNT_W     = 11;
  localparam int BOX_W       = 18;
  localparam int CMP_W       = 17;
  localparam int SUM_W       = 64;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDXF_W - ADDRF_W - POOL_W - COUNT_W;
  localparam int IN_PAD_W    = IN_TDATA_W - IDXF_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_ID      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 3'd3;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_FREE = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_POP
  } bpfl_state_t;

  typedef struct packed {
    logic sweep;
    logic accept;
    logic eval_done;
    logic pop_done;
  } bpfl_cmd_t;

  typedef struct packed {
    logic restart;
    logic sweep_last;
    logic slot_free;
    logic alloc_go;
  } bpfl_stat_t;

endpackage

FILE: hdl/bpfl_ctrl.sv
// Controller state machine sequencing clearing, requests and result loads.
`timescale 1ns / 1ps
module bpfl_ctrl
  import bpfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  bpfl_stat_t stat,
  output bpfl_cmd_t  cmd
);

  bpfl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (stat.restart) begin
      state_nxt = ST_CLEAR;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (stat.sweep_last) state_nxt = ST_IDLE;
        end
        ST_IDLE: begin
          if (in_tvalid) state_nxt = ST_EVAL;
        end
        ST_EVAL: begin
          if (stat.alloc_go) begin
            state_nxt = ST_POP;
          end else if (stat.slot_free) begin
            state_nxt = ST_IDLE;
          end
        end
        ST_POP: begin
          if (stat.slot_free) state_nxt = ST_IDLE;
        end
        default: state_nxt = ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    cmd.sweep     = (state_r == ST_CLEAR);
    cmd.accept    = (state_r == ST_IDLE) && in_tvalid;
    cmd.eval_done = (state_r == ST_EVAL) && !stat.alloc_go && stat.slot_free;
    cmd.pop_done  = (state_r == ST_POP) && stat.slot_free;
  end

endmodule

FILE: hdl/bpfl_dp.sv
// Datapath: configuration, link memory, head and count, address and result registers.
`timescale 1ns / 1ps
module bpfl_dp
  import bpfl_pkg::*;
#(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_req_type,
  input  logic [IDXF_W-1:0]     in_free_index,
  input  logic                  out_tready,
  input  bpfl_cmd_t             cmd,
  output bpfl_stat_t            stat,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [IDXF_W-1:0]     out_block_index,
  output logic [ADDRF_W-1:0]    out_block_address,
  output logic [POOL_W-1:0]     out_handle_pool,
  output logic [COUNT_W-1:0]    out_free_count
);

  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
  localparam int LW1    = LINK_W + 1;
  localparam int PROD_W = IDX_W + BOX_W;
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_BLOCKS);
  localparam logic [SUM_W-1:0]  AMASK    = {SUM_W{1'b1}} >> (SUM_W - ADDR_WIDTH);

  logic [NUMB_W-1:0]  num_blocks_r;
  logic [BYTES_W-1:0] block_bytes_r;
  logic [POOL_W-1:0]  pool_id_r;
  logic [BASE_W-1:0]  base_address_r;
  logic               cfg_known;

  logic [LINK_W-1:0] sw_r;
  logic [LINK_W-1:0] head_r;
  logic [LINK_W-1:0] free_total_r;
  logic              req_r;
  logic [IDXF_W-1:0] idx_r;
  logic [LINK_W-1:0] mem_r [MAX_BLOCKS];
  logic [LINK_W-1:0] rd_r;
  logic [PROD_W-1:0] prod_r;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [IDXF_W-1:0]    out_index_r;
  logic [ADDRF_W-1:0]   out_addr_r;
  logic [POOL_W-1:0]    out_pool_r;
  logic [COUNT_W-1:0]   out_count_r;

  logic [LINK_W-1:0] n;
  logic [LW1-1:0]    sw_inc;
  logic [LINK_W-1:0] sweep_link;
  logic [IDX_W-1:0]  head_idx;
  logic [BOX_W-1:0]  box;
  logic [SUM_W-1:0]  addr_sum;
  logic              free_ok;
  logic              slot_free;

  always_comb begin
    unique case (cfg_index)
      CFG_NUM_BLOCKS, CFG_BLOCK_BYTES, CFG_POOL_ID, CFG_BASE_ADDRESS: cfg_known = 1'b1;
      default: cfg_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_blocks_r   <= NUMB_W'(1024);
      block_bytes_r  <= BYTES_W'(64);
      pool_id_r      <= '0;
      base_address_r <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_NUM_BLOCKS:   num_blocks_r   <= cfg_data[NUMB_W-1:0];
        CFG_BLOCK_BYTES:  block_bytes_r  <= cfg_data[BYTES_W-1:0];
        CFG_POOL_ID:      pool_id_r      <= cfg_data[POOL_W-1:0];
        CFG_BASE_ADDRESS: base_address_r <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (CMP_W'(num_blocks_r) > CMP_W'(MAX_BLOCKS)) begin
      n = END_MARK;
    end else begin
      n = LINK_W'(num_blocks_r);
    end
    sw_inc     = LW1'(sw_r) + LW1'(1);
    sweep_link = (sw_inc < LW1'(n)) ? LINK_W'(sw_inc) : END_MARK;
    head_idx   = head_r[IDX_W-1:0];
    box        = ((BOX_W'(block_bytes_r) + BOX_W'(15)) & ~BOX_W'(15))
               + BOX_W'(HEADER_BYTES);
    addr_sum   = (SUM_W'(base_address_r) + SUM_W'(prod_r) + SUM_W'(HEADER_BYTES)) & AMASK;
    free_ok    = (CMP_W'(idx_r) < CMP_W'(n)) && (free_total_r < n);
    slot_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    stat.restart    = cfg_write && cfg_known;
    stat.sweep_last = (sw_r == LINK_W'(MAX_BLOCKS - 1));
    stat.slot_free  = slot_free;
    stat.alloc_go   = (req_r == REQ_ALLOC) && (head_r < END_MARK) && (free_total_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || stat.restart) begin
      sw_r <= '0;
    end else if (cmd.sweep) begin
      sw_r <= sw_r + LINK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      free_total_r <= '0;
    end else if (cmd.sweep) begin
      head_r       <= (n == '0) ? END_MARK : '0;
      free_total_r <= n;
    end else if (cmd.eval_done && (req_r == REQ_FREE) && free_ok) begin
      head_r       <= LINK_W'(idx_r);
      free_total_r <= free_total_r + LINK_W'(1);
    end else if (cmd.pop_done) begin
      head_r       <= rd_r;
      free_total_r <= free_total_r - LINK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_req_type;
      idx_r <= in_free_index;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem_r[sw_r[IDX_W-1:0]] <= sweep_link;
    end else if (cmd.eval_done && (req_r == REQ_FREE) && free_ok) begin
      mem_r[IDX_W'(idx_r)] <= head_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_r   <= mem_r[head_idx];
    prod_r <= PROD_W'(head_idx) * PROD_W'(box);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.eval_done || cmd.pop_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_done) begin
      out_status_r <= STAT_OK;
      out_index_r  <= IDXF_W'(head_r);
      out_addr_r   <= addr_sum[ADDRF_W-1:0];
      out_pool_r   <= pool_id_r;
      out_count_r  <= COUNT_W'(free_total_r - LINK_W'(1));
    end else if (cmd.eval_done) begin
      out_index_r <= '0;
      out_addr_r  <= '0;
      out_pool_r  <= '0;
      if (req_r == REQ_FREE) begin
        out_status_r <= free_ok ? STAT_OK : STAT_BAD_FREE;
        out_count_r  <= free_ok ? COUNT_W'(free_total_r + LINK_W'(1))
                                : COUNT_W'(free_total_r);
      end else begin
        out_status_r <= STAT_EMPTY;
        out_count_r  <= COUNT_W'(free_total_r);
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_index   = out_index_r;
  assign out_block_address = out_addr_r;
  assign out_handle_pool   = out_pool_r;
  assign out_free_count    = out_count_r;

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= END_MARK)
    else $error("free count above pool size");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= END_MARK)
    else $error("head link out of range");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval_done || cmd.pop_done) |-> (!out_valid_r || out_tready))
    else $error("result loaded over a waiting result");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_done |-> (free_total_r != '0) && (head_r < END_MARK))
    else $error("pop from an empty list");

endmodule

FILE: hdl/block_pool_free_list_allocator_core.sv
// Top level of the block pool free list allocator.
//
// Requests arrive on the in_ stream: tuser selects allocate (0) or free (1),
// tdata carries the index to free. Each request gives one result on the out_
// stream (none if a restart comes first): tuser holds the status, tdata the
// block index, payload byte address, pool id and free count. Allocates hand
// out the most recently freed block first; after a restart blocks come out in
// order from 0 upward. A free, an empty allocate or a bad free passes through
// the EVAL state before out_tvalid rises; a successful allocate passes through
// EVAL and then POP, because the head's next link is read from the link memory
// before the head moves. Requests are handled one at a time: the next one is
// taken only once the previous result has been loaded.
// Reset, and every write to a known register on the cfg_ port, starts a
// clearing pass that rebuilds all MAX_BLOCKS link memory entries; no request
// is taken meanwhile, configuration writes still are.
// The result register decouples the sides: a new request is taken while a
// result waits, and the request then holds until out_tready frees the slot.
`timescale 1ns / 1ps
module block_pool_free_list_allocator_core
  import bpfl_pkg::*;
#(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] free_index
  input  logic                   in_tuser,   // [0] req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] block_index, [41:10] block_address,
                                             // [49:42] handle_pool, [60:50] free_count
  output logic [STATUS_W-1:0]    out_tuser   // [1:0] status
);

  bpfl_cmd_t          cmd;
  bpfl_stat_t         stat;
  logic [IDXF_W-1:0]  blk_index;
  logic [ADDRF_W-1:0] blk_addr;
  logic [POOL_W-1:0]  blk_pool;
  logic [COUNT_W-1:0] free_cnt;
  logic [IN_PAD_W-1:0] in_pad_unused;

  assign cfg_ready     = 1'b1;
  assign in_pad_unused = in_tdata[IN_TDATA_W-1:IDXF_W];

  bpfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpfl_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_req_type       (in_tuser),
    .in_free_index     (in_tdata[IDXF_W-1:0]),
    .out_tready        (out_tready),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_tvalid),
    .out_status        (out_tuser),
    .out_block_index   (blk_index),
    .out_block_address (blk_addr),
    .out_handle_pool   (blk_pool),
    .out_free_count    (free_cnt)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, free_cnt, blk_pool, blk_addr, blk_index};

endmodule
